// ===== sv/acsdk_pkg.sv =====
// Shared types, constants and character helpers for the alphanumeric Caesar block.
`timescale 1ns / 1ps

package acsdk_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT_KEY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DYN_MODE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DYN_ENC   = 2'd2;

  // alphanumeric count width (segment depth must stay at or below 63; not checked)
  localparam int unsigned CntW = 6;

  // command queue between front and back
  localparam int unsigned CmdqDepth = 4;

  localparam logic [7:0] CHR_HYPHEN = 8'h2d;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_CR     = 8'h0d;
  localparam logic [7:0] CHR_LA     = 8'h61;
  localparam logic [7:0] CHR_LZ     = 8'h7a;
  localparam logic [7:0] CHR_UA     = 8'h41;
  localparam logic [7:0] CHR_UZ     = 8'h5a;
  localparam logic [7:0] CHR_D0     = 8'h30;
  localparam logic [7:0] CHR_D9     = 8'h39;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       overflow;
  } out_item_t;

  typedef enum logic {
    ACT_EMIT = 1'b0,
    ACT_HOLD = 1'b1
  } act_e;

  // one command per accepted word: optional segment release plus the byte itself
  typedef struct packed {
    act_e       act;
    logic       rel;
    logic       ovf;
    logic [7:0] chr;
    logic [4:0] ek26;
    logic [3:0] ek10;
    logic [4:0] rk26;
    logic [3:0] rk10;
  } cmd_t;

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = (c >= CHR_LA && c <= CHR_LZ) || (c >= CHR_UA && c <= CHR_UZ) ||
               (c >= CHR_D0 && c <= CHR_D9);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CHR_SPACE) || (c >= CHR_TAB && c <= CHR_CR);
  endfunction

  // rotate by keys already reduced mod 26 and mod 10
  function automatic logic [7:0] rotate_chr(input logic [7:0] c, input logic [4:0] k26,
                                            input logic [3:0] k10);
    logic [5:0] t;
    logic [4:0] d;
    t = '0;
    d = '0;
    rotate_chr = c;
    if (c >= CHR_LA && c <= CHR_LZ) begin
      t = 6'(c - CHR_LA) + 6'(k26);
      if (t >= 6'd26) t = t - 6'd26;
      rotate_chr = CHR_LA + 8'(t);
    end else if (c >= CHR_UA && c <= CHR_UZ) begin
      t = 6'(c - CHR_UA) + 6'(k26);
      if (t >= 6'd26) t = t - 6'd26;
      rotate_chr = CHR_UA + 8'(t);
    end else if (c >= CHR_D0 && c <= CHR_D9) begin
      d = 5'(c - CHR_D0) + 5'(k10);
      if (d >= 5'd10) d = d - 5'd10;
      rotate_chr = CHR_D0 + 8'(d);
    end
  endfunction

endpackage

// ===== sv/acsdk_front.sv =====
// Front end: accepts input words, classifies them, tracks segment state, issues commands.
`timescale 1ns / 1ps

module acsdk_front import acsdk_pkg::*; #(
  parameter int unsigned SEGMENT_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_data_i,
  input  logic [CfgDataW-1:0] shift_key_i,
  input  logic                dyn_mode_i,
  input  logic                dyn_enc_i,
  input  logic                cmd_full_i,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o
);

  localparam int unsigned FillW = $clog2(SEGMENT_DEPTH + 1);
  localparam logic [FillW-1:0] FillFull = FillW'(SEGMENT_DEPTH);

  logic [FillW-1:0] fill_q, fill_d, fill_inc;
  logic [FillW-1:0] alnum_q, alnum_d, alnum_inc, rel_cnt;
  logic             hyphen_q, hyphen_d;
  logic             accept;

  // static key reduction: offset by a common multiple of 26 and 10 to go positive,
  // then reciprocal multiply
  logic [11:0] key_u, s_r26, s_r10;
  logic [23:0] prod26;
  logic [24:0] prod10;
  logic [6:0]  s_q26;
  logic [7:0]  s_q10;

  // dynamic key reduction from the alphanumeric count
  logic [CntW-1:0] cnt, d_r26, d_r10;
  logic [13:0]     cnt_p;
  logic [2:0]      d_q10;
  logic [4:0]      rk26;
  logic [3:0]      rk10;

  assign accept      = push && !cmd_full_i;
  assign full        = cmd_full_i;
  assign cmd_valid_o = accept;

  always_comb begin
    key_u  = 12'({shift_key_i[CfgDataW-1], shift_key_i}) + 12'd1040;
    prod26 = 24'(key_u) * 24'd2521;
    prod10 = 25'(key_u) * 25'd6554;
    s_q26  = prod26[22:16];
    s_q10  = prod10[23:16];
    s_r26  = key_u - 12'(12'(s_q26) * 12'd26);
    s_r10  = key_u - 12'(12'(s_q10) * 12'd10);
  end

  assign fill_inc  = fill_q + FillW'(1);
  assign alnum_inc = alnum_q + FillW'(is_alnum(in_data_i.in_char));
  assign rel_cnt   = (dyn_mode_i && !is_space(in_data_i.in_char) &&
                      !(in_data_i.in_char == CHR_HYPHEN && !hyphen_q)) ? alnum_inc : alnum_q;

  always_comb begin
    cnt   = CntW'(rel_cnt);
    d_r26 = (cnt >= 6'd52) ? cnt - 6'd52 : ((cnt >= 6'd26) ? cnt - 6'd26 : cnt);
    cnt_p = 14'(cnt) * 14'd205;
    d_q10 = cnt_p[13:11];
    d_r10 = cnt - 6'(6'(d_q10) * 6'd10);
    rk26  = d_r26[4:0];
    rk10  = d_r10[3:0];
    // decrypt shifts backward
    if (!dyn_enc_i) begin
      rk26 = (rk26 == 5'd0) ? 5'd0 : 5'd26 - rk26;
      rk10 = (rk10 == 4'd0) ? 4'd0 : 4'd10 - rk10;
    end
  end

  always_comb begin
    fill_d   = fill_q;
    alnum_d  = alnum_q;
    hyphen_d = hyphen_q;
    cmd_o.act  = ACT_EMIT;
    cmd_o.rel  = (fill_q != '0);
    cmd_o.ovf  = 1'b0;
    cmd_o.chr  = in_data_i.in_char;
    cmd_o.ek26 = '0;
    cmd_o.ek10 = '0;
    cmd_o.rk26 = rk26;
    cmd_o.rk10 = rk10;
    if (!dyn_mode_i) begin
      cmd_o.ek26 = s_r26[4:0];
      cmd_o.ek10 = s_r10[3:0];
      fill_d     = '0;
      alnum_d    = '0;
      hyphen_d   = 1'b0;
    end else if (is_space(in_data_i.in_char)) begin
      fill_d   = '0;
      alnum_d  = '0;
      hyphen_d = 1'b0;
    end else if (in_data_i.in_char == CHR_HYPHEN && !hyphen_q) begin
      fill_d   = '0;
      alnum_d  = '0;
      hyphen_d = 1'b1;
    end else begin
      cmd_o.act = ACT_HOLD;
      if (fill_inc == FillFull) begin
        cmd_o.rel = 1'b1;
        cmd_o.ovf = 1'b1;
        fill_d    = '0;
        alnum_d   = '0;
      end else if (in_data_i.end_of_text) begin
        cmd_o.rel = 1'b1;
        fill_d    = '0;
        alnum_d   = '0;
      end else begin
        cmd_o.rel = 1'b0;
        fill_d    = fill_inc;
        alnum_d   = alnum_inc;
      end
    end
    if (in_data_i.end_of_text) hyphen_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      alnum_q  <= '0;
      hyphen_q <= 1'b0;
    end else if (accept) begin
      fill_q   <= fill_d;
      alnum_q  <= alnum_d;
      hyphen_q <= hyphen_d;
    end
  end

endmodule

// ===== sv/acsdk_cmdq.sv =====
// Small command queue decoupling the front end from the back end.
`timescale 1ns / 1ps

module acsdk_cmdq import acsdk_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  output logic rd_valid_o,
  input  logic rd_pop_i,
  output cmd_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(CmdqDepth);

  cmd_t            entry_q [CmdqDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            do_wr, do_rd;

  assign full_o     = (cnt_q == (PtrW + 1)'(CmdqDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = entry_q[rp_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) entry_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= wp_q + PtrW'(1);
      if (do_rd) rp_q <= rp_q + PtrW'(1);
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + (PtrW + 1)'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - (PtrW + 1)'(1);
      end
    end
  end

endmodule

// ===== sv/acsdk_back.sv =====
// Back end: segment buffer, replay of held segments and output register.
`timescale 1ns / 1ps

module acsdk_back import acsdk_pkg::*; #(
  parameter int unsigned SEGMENT_DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data_o
);

  localparam int unsigned FillW = $clog2(SEGMENT_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(SEGMENT_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REL,
    ST_EMIT
  } state_e;

  logic [7:0]       seg_mem [SEGMENT_DEPTH];
  state_e           state_q, state_d;
  cmd_t             cur_q, cur_d;
  logic [FillW-1:0] wp_q, wp_d, ri_q, ri_d;
  logic             rd_valid_q, rd_valid_d;
  logic [7:0]       rd_data_q;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free, out_load, mem_we, rd_en;

  assign out_free   = !out_valid_q || pop;
  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    wp_d        = wp_q;
    ri_d        = ri_q;
    rd_valid_d  = rd_valid_q;
    out_d       = out_q;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    cmd_pop_o   = 1'b0;
    out_valid_d = out_valid_q && !pop;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          ri_d      = '0;
          if (cmd_i.act == ACT_HOLD) begin
            mem_we = 1'b1;
            wp_d   = wp_q + FillW'(1);
          end
          if (cmd_i.rel) begin
            state_d = ST_REL;
          end else if (cmd_i.act == ACT_EMIT) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_REL: begin
        // one-deep read stage in front of the output register
        if (rd_valid_q && out_free) begin
          out_load          = 1'b1;
          out_d.out_char    = rotate_chr(rd_data_q, cur_q.rk26, cur_q.rk10);
          out_d.overflow    = cur_q.ovf;
          out_d.last_of_run = (ri_q == wp_q) && (cur_q.act == ACT_HOLD);
          rd_valid_d        = 1'b0;
        end
        if (!rd_valid_q || out_free) begin
          if (ri_q != wp_q) begin
            rd_en      = 1'b1;
            ri_d       = ri_q + FillW'(1);
            rd_valid_d = 1'b1;
          end else begin
            wp_d    = '0;
            state_d = (cur_q.act == ACT_HOLD) ? ST_IDLE : ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.out_char    = rotate_chr(cur_q.chr, cur_q.ek26, cur_q.ek10);
          out_d.last_of_run = 1'b1;
          out_d.overflow    = 1'b0;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) seg_mem[wp_q[AddrW-1:0]] <= cmd_i.chr;
    if (rd_en) rd_data_q <= seg_mem[ri_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      out_q       <= '0;
      wp_q        <= '0;
      ri_q        <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_q       <= out_d;
      wp_q        <= wp_d;
      ri_q        <= ri_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/alnum_caesar_shift_dynamic_key.sv =====
// Top level: alphanumeric Caesar rotation of a byte stream with static or per-segment key.
// Input side is a queue: a word (byte plus end-of-text flag) is taken when push is high
// and full is low. Output side is a queue: the oldest result sits on out_data_o while
// empty is low and is taken when pop is high. Configuration is a valid/ready write port
// (index 0 shift key, 1 dynamic mode, 2 dynamic direction), always ready; write it only
// while the block is idle.
// Static mode: each byte gives one rotated result; the first byte after dynamic mode also
// releases any held segment. The back end fetches and then emits each byte, which sets
// the sustained rate. Dynamic mode: a held byte is only written to the segment buffer;
// a released segment is replayed from it at one byte per cycle while the output is not
// stalled; a delimiter byte follows. The front end keeps taking words via a 4-entry
// command queue while the back end replays, so full rises only when that queue is full.
// A stalled receiver holds the output register; the back end then waits and the queue
// fills behind it. Reset empties both queues, clears segment state and config registers.
`timescale 1ns / 1ps

module alnum_caesar_shift_dynamic_key import acsdk_pkg::*; #(
  parameter int unsigned SEGMENT_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_data_i,
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [CfgDataW-1:0] shift_key_q;
  logic                dyn_mode_q, dyn_enc_q;
  logic                cmdq_full, front_valid, cmdq_valid, cmdq_pop;
  cmd_t                front_cmd, cmdq_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_key_q <= '0;
      dyn_mode_q  <= 1'b0;
      dyn_enc_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SHIFT_KEY: shift_key_q <= cfg_data_i;
        CFG_DYN_MODE:  dyn_mode_q  <= cfg_data_i[0];
        CFG_DYN_ENC:   dyn_enc_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  acsdk_front #(
    .SEGMENT_DEPTH(SEGMENT_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .shift_key_i (shift_key_q),
    .dyn_mode_i  (dyn_mode_q),
    .dyn_enc_i   (dyn_enc_q),
    .cmd_full_i  (cmdq_full),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  acsdk_cmdq u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_data_i  (front_cmd),
    .full_o     (cmdq_full),
    .rd_valid_o (cmdq_valid),
    .rd_pop_i   (cmdq_pop),
    .rd_data_o  (cmdq_cmd)
  );

  acsdk_back #(
    .SEGMENT_DEPTH(SEGMENT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmdq_valid),
    .cmd_i       (cmdq_cmd),
    .cmd_pop_o   (cmdq_pop),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/caesar_stream_checker.sv =====
// Checker for the alphanumeric Caesar block: predicts results from accepted words and compares.
`timescale 1ns / 1ps

module caesar_stream_checker import acsdk_pkg::*; #(
  parameter int unsigned SEG_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  logic                full,
  input  in_item_t            in_data_i,
  input  logic                empty,
  input  logic                pop,
  input  out_item_t           out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_cnt_o,
  output int                  pending_o
);

  logic signed [CfgDataW-1:0] key_q;
  logic                       dyn_q;
  logic                       enc_q;

  logic [7:0]  seg_mem [SEG_DEPTH];
  int unsigned seg_fill;
  int unsigned seg_alnum;
  logic        hyph_q;

  out_item_t due_q[$];   // cipher words still owed by the block
  out_item_t run_q[$];   // words produced by the current input word
  out_item_t head;

  function automatic logic [7:0] rot_char(input logic [7:0] c, input int k);
    int k26;
    int k10;
    k26 = k % 26;
    if (k26 < 0) k26 += 26;
    k10 = k % 10;
    if (k10 < 0) k10 += 10;
    if (c >= CHR_LA && c <= CHR_LZ)
      return 8'(int'(CHR_LA) + (int'(c) - int'(CHR_LA) + k26) % 26);
    if (c >= CHR_UA && c <= CHR_UZ)
      return 8'(int'(CHR_UA) + (int'(c) - int'(CHR_UA) + k26) % 26);
    if (c >= CHR_D0 && c <= CHR_D9)
      return 8'(int'(CHR_D0) + (int'(c) - int'(CHR_D0) + k10) % 10);
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR);
  endfunction

  function automatic logic is_letter_digit(input logic [7:0] c);
    return (c >= CHR_LA && c <= CHR_LZ) || (c >= CHR_UA && c <= CHR_UZ) ||
           (c >= CHR_D0 && c <= CHR_D9);
  endfunction

  // replay the held segment, shifted by its letter/digit count
  task automatic flush_seg(input logic ovf);
    int k;
    k = enc_q ? int'(seg_alnum) : -int'(seg_alnum);
    for (int unsigned i = 0; i < seg_fill; i++)
      run_q.push_back('{rot_char(seg_mem[i], k), 1'b0, ovf});
    seg_fill  = 0;
    seg_alnum = 0;
  endtask

  task automatic caesar_step(input in_item_t w);
    logic [7:0] c;
    out_item_t  tail;
    c = w.in_char;
    run_q.delete();
    if (!dyn_q) begin
      // a segment left over from dynamic mode goes out first
      flush_seg(1'b0);
      run_q.push_back('{rot_char(c, int'(key_q)), 1'b0, 1'b0});
      hyph_q = 1'b0;
    end else if (is_blank(c) || (c == CHR_HYPHEN && !hyph_q)) begin
      flush_seg(1'b0);
      run_q.push_back('{c, 1'b0, 1'b0});
      hyph_q = !is_blank(c);
    end else begin
      if (seg_fill < SEG_DEPTH) begin
        seg_mem[seg_fill] = c;
        seg_fill++;
        if (is_letter_digit(c)) seg_alnum++;
      end
      if (seg_fill >= SEG_DEPTH) flush_seg(1'b1);
    end
    if (dyn_q && w.end_of_text) flush_seg(1'b0);
    if (w.end_of_text) hyph_q = 1'b0;
    if (run_q.size() > 0) begin
      tail = run_q.pop_back();
      tail.last_of_run = 1'b1;
      run_q.push_back(tail);
    end
    foreach (run_q[i]) due_q.push_back(run_q[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      = '0;
      dyn_q      = 1'b0;
      enc_q      = 1'b0;
      seg_fill   = 0;
      seg_alnum  = 0;
      hyph_q     = 1'b0;
      due_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SHIFT_KEY: key_q = cfg_data_i;
          CFG_DYN_MODE:  dyn_q = cfg_data_i[0];
          CFG_DYN_ENC:   enc_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (due_q.size() == 0) begin
          $error("unexpected word: out_char %h", out_data_i.out_char);
          fail_cnt_o++;
        end else begin
          head = due_q.pop_front();
          if (out_data_i.out_char !== head.out_char) begin
            $error("out_char: expected %h, got %h", head.out_char, out_data_i.out_char);
            fail_cnt_o++;
          end
          if (out_data_i.last_of_run !== head.last_of_run) begin
            $error("last_of_run: expected %b, got %b", head.last_of_run,
                   out_data_i.last_of_run);
            fail_cnt_o++;
          end
          if (out_data_i.overflow !== head.overflow) begin
            $error("overflow: expected %b, got %b", head.overflow, out_data_i.overflow);
            fail_cnt_o++;
          end
        end
      end
      if (push && !full) caesar_step(in_data_i);
      pending_o = due_q.size();
    end
  end

endmodule

// ===== test/alnum_caesar_shift_dynamic_key_test.sv =====
// Stimulus and verdict for the alphanumeric Caesar block, checked by caesar_stream_checker.
`timescale 1ns / 1ps

module alnum_caesar_shift_dynamic_key_test;
  import acsdk_pkg::*;

  localparam int unsigned SegDepth   = 32;
  localparam int unsigned DrainWait  = 40;   // covers bytes still queued with no result
  localparam int          CycleLimit = 200000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  in_item_t            in_data = '0;
  logic                empty;
  logic                pop = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int          fails;
  int          pending;
  int          cycles = 0;
  int unsigned sent = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  alnum_caesar_shift_dynamic_key #(.SEGMENT_DEPTH(SegDepth)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  caesar_stream_checker #(.SEG_DEPTH(SegDepth)) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data),
    .empty       (empty),
    .pop         (pop),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fails),
    .pending_o   (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // called at a falling edge; leaves push high after the word is taken
  task automatic send_byte(input logic [7:0] c, input logic eot);
    while ($urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    in_data <= '{c, eot};
    do @(posedge clk_i); while (full);
    sent++;
    @(negedge clk_i);
  endtask

  // stop sending until every owed word has been popped
  task automatic settle(input int unsigned extra);
    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  task automatic apply_cfg(input int key, input logic dyn, input logic enc);
    settle(DrainWait);
    put_reg(CFG_SHIFT_KEY, CfgDataW'(key));
    put_reg(CFG_DYN_MODE, CfgDataW'(dyn));
    put_reg(CFG_DYN_ENC, CfgDataW'(enc));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] text_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'(int'(CHR_LA) + $urandom_range(0, 25));
    if (r < 55) return 8'(int'(CHR_UA) + $urandom_range(0, 25));
    if (r < 70) return 8'(int'(CHR_D0) + $urandom_range(0, 9));
    if (r < 80) return CHR_HYPHEN;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] gap_char();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(int'(CHR_TAB), int'(CHR_CR)));
    return CHR_SPACE;
  endfunction

  task automatic send_word(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_byte(text_char(), $urandom_range(0, 39) == 0);
    send_byte(gap_char(), $urandom_range(0, 9) == 0);
  endtask

  initial begin
    int unsigned base;
    int          key;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // static rotation with large positive and negative keys, field extremes, pass-through bytes
    apply_cfg(1000, 1'b0, 1'b0);
    send_byte(CHR_LA, 1'b0);
    send_byte(CHR_LZ, 1'b0);
    send_byte(CHR_UA, 1'b0);
    send_byte(CHR_UZ, 1'b0);
    send_byte(CHR_D0, 1'b0);
    send_byte(CHR_D9, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(CHR_HYPHEN, 1'b0);
    send_byte(CHR_SPACE, 1'b1);
    apply_cfg(-1000, 1'b0, 1'b0);
    send_byte("m", 1'b0);
    send_byte("5", 1'b0);
    send_byte(8'h80, 1'b1);

    // dynamic: first hyphen releases, second is held, tab releases, end of text flushes
    apply_cfg(0, 1'b1, 1'b1);
    send_byte("a", 1'b0);
    send_byte("1", 1'b0);
    send_byte(CHR_HYPHEN, 1'b0);
    send_byte("b", 1'b0);
    send_byte(CHR_HYPHEN, 1'b0);
    send_byte("c", 1'b0);
    send_byte(CHR_TAB, 1'b0);
    send_byte("Z", 1'b0);
    send_byte("z", 1'b1);

    // segment still held when the mode drops back to static
    send_byte("x", 1'b0);
    send_byte("y", 1'b0);
    apply_cfg(7, 1'b0, 1'b1);
    send_byte("q", 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      key = (ph == 0) ? 1000 : (ph == 1) ? -1000 : int'($urandom_range(0, 2000)) - 1000;
      apply_cfg(key, (ph != 0 && ph != 5), ph[0]);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 73; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 73; end
        default: begin gap_pct = 19; stall_pct = 19; end
      endcase
      base = sent;
      if (ph == 1) send_word(36);   // long word fills the segment buffer
      while (sent - base < 4) begin
        send_word($urandom_range(1, 8));
        if (ph == 6 && sent - base < 4) settle(0);
      end
    end

    settle(50);
    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/acsdk_pkg.sv
sv/acsdk_front.sv
sv/acsdk_cmdq.sv
sv/acsdk_back.sv
sv/alnum_caesar_shift_dynamic_key.sv
test/caesar_stream_checker.sv
test/alnum_caesar_shift_dynamic_key_test.sv
